// ===== design/i2c_master_write_engine_core_macros.svh =====
// ----------------------------------------------------------------------------
// I2C write engine assertion macros
// Shared concurrent assertion shorthands for the write engine RTL.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_WRITE_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_WRITE_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define I2CW_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("i2cw same-cycle check failed");
`define I2CW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("i2cw next-cycle check failed");
`else
`define I2CW_ASSERT_SAME(lbl, ante, cons)
`define I2CW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/i2cw_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C write engine package
// Phase and command codes, register indexes and shared state types.
// ----------------------------------------------------------------------------
package i2cw_pkg;

    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 8;

    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST_A    = 4'd1,
        PH_ST_B    = 4'd2,
        PH_ST_C    = 4'd3,
        PH_SP_A    = 4'd4,
        PH_SP_B    = 4'd5,
        PH_SP_C    = 4'd6,
        PH_WR_LOW  = 4'd7,
        PH_WR_DATA = 4'd8,
        PH_WR_HIGH = 4'd9,
        PH_WR_END  = 4'd10,
        PH_AK_RISE = 4'd11,
        PH_AK_POLL = 4'd12,
        PH_AK_FALL = 4'd13,
        PH_AK_DROP = 4'd14
    } phase_t;

    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_STOP     = 2'd1,
        OP_WRITE    = 2'd2,
        OP_ACK_WAIT = 2'd3
    } op_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] bit_index;
        logic [7:0] shift_byte;
        logic [7:0] delay_count;
        logic [7:0] poll_count;
        logic       scl;
        logic       sda;
        logic       nack_pending;
    } state_t;

    typedef struct packed {
        logic [7:0] half_period;
        logic [7:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic done;
        logic nack;
    } res_t;

    function automatic logic [7:0] arm_delay(input logic [7:0] hp);
        return (hp == 8'd0) ? 8'd1 : hp;
    endfunction

endpackage

// ===== design/i2cw_step.sv =====
// ----------------------------------------------------------------------------
// I2C write engine tick logic
// Next sequencer state and bus levels for one timebase tick.
// ----------------------------------------------------------------------------
module i2cw_step
    import i2cw_pkg::*;
(
    input  state_t     st,
    input  cfg_t       cfg,
    input  logic       cmd_valid,
    input  op_t        operation,
    input  logic [7:0] write_data,
    input  logic       sda_in,
    output state_t     nx,
    output res_t       res
);

    logic [7:0] arm_val;
    logic [3:0] bit_inc;
    logic       done;
    logic       done_nack;
    state_t     poll_st;

    assign arm_val = arm_delay(cfg.half_period);
    assign bit_inc = st.bit_index + 4'd1;

    // acknowledge poll, shared by the rise phase and the poll phase
    always_comb begin
        poll_st = st;
        poll_st.phase = PH_AK_POLL;
        poll_st.delay_count = 8'd0;
        if (!sda_in) begin
            poll_st.scl = 1'b0;
            poll_st.delay_count = arm_val;
            poll_st.phase = PH_AK_FALL;
        end else if (st.poll_count >= cfg.ack_timeout) begin
            poll_st.scl = 1'b0;
            poll_st.delay_count = arm_val;
            poll_st.phase = PH_AK_DROP;
        end else begin
            poll_st.poll_count = st.poll_count + 8'd1;
        end
    end

    always_comb begin
        nx = st;
        done = 1'b0;
        done_nack = 1'b0;
        if (st.phase == PH_IDLE) begin
            if (cmd_valid) begin
                nx.delay_count = arm_val;
                case (operation)
                    OP_START: begin
                        nx.sda = 1'b1;
                        nx.scl = 1'b1;
                        nx.phase = PH_ST_A;
                    end
                    OP_STOP: begin
                        nx.sda = 1'b0;
                        nx.nack_pending = 1'b0;
                        nx.phase = PH_SP_A;
                    end
                    OP_WRITE: begin
                        nx.shift_byte = write_data;
                        nx.bit_index = 4'd0;
                        nx.scl = 1'b0;
                        nx.phase = PH_WR_LOW;
                    end
                    default: begin
                        nx.scl = 1'b1;
                        nx.sda = 1'b1;
                        nx.poll_count = 8'd0;
                        nx.phase = PH_AK_RISE;
                    end
                endcase
            end
        end else if (st.phase == PH_AK_POLL) begin
            nx = poll_st;
        end else if (st.delay_count > 8'd1) begin
            nx.delay_count = st.delay_count - 8'd1;
        end else begin
            nx.delay_count = arm_val;
            case (st.phase)
                PH_ST_A: begin
                    nx.sda = 1'b0;
                    nx.phase = PH_ST_B;
                end
                PH_ST_B: begin
                    nx.scl = 1'b0;
                    nx.phase = PH_ST_C;
                end
                PH_SP_A: begin
                    nx.scl = 1'b1;
                    nx.phase = PH_SP_B;
                end
                PH_SP_B: begin
                    nx.sda = 1'b1;
                    nx.phase = PH_SP_C;
                end
                PH_WR_LOW: begin
                    nx.sda = st.shift_byte[7];
                    nx.phase = PH_WR_DATA;
                end
                PH_WR_DATA: begin
                    nx.scl = 1'b1;
                    nx.phase = PH_WR_HIGH;
                end
                PH_WR_HIGH: begin
                    nx.scl = 1'b0;
                    nx.shift_byte = {st.shift_byte[6:0], 1'b0};
                    nx.bit_index = bit_inc;
                    nx.phase = (bit_inc >= 4'd8) ? PH_WR_END : PH_WR_LOW;
                end
                PH_AK_RISE: begin
                    nx = poll_st;
                end
                PH_AK_DROP: begin
                    nx.sda = 1'b0;
                    nx.nack_pending = 1'b1;
                    nx.phase = PH_SP_A;
                end
                PH_ST_C, PH_SP_C, PH_WR_END, PH_AK_FALL: begin
                    nx.phase = PH_IDLE;
                    nx.delay_count = 8'd0;
                    nx.nack_pending = 1'b0;
                    done = 1'b1;
                    done_nack = (st.phase == PH_SP_C) ? st.nack_pending : 1'b0;
                end
                default: begin
                    nx.phase = PH_IDLE;
                    nx.delay_count = 8'd0;
                end
            endcase
        end
    end

    always_comb begin
        res.scl = nx.scl;
        res.sda = nx.sda;
        res.busy = (nx.phase != PH_IDLE);
        res.done = done;
        res.nack = done_nack;
    end

endmodule

// ===== design/i2c_master_write_engine_core.sv =====
// ----------------------------------------------------------------------------
// I2C master write engine
// Write-only I2C sequencer stepped once per timebase tick request.
// ----------------------------------------------------------------------------
// Result: registered; it appears on m_tvalid/m_tdata in the cycle after request accept.
// Throughput: one request per cycle while m_tready is high or the output register
//   is empty; the state register and the result register update on the same edge.
// Reset: synchronous, active low; phase idle, lines released, registers
//   back to half period 5 and ack timeout 250, output register empty.
`include "i2c_master_write_engine_core_macros.svh"

module i2c_master_write_engine_core
    import i2cw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // write_data[7:0], sda_in[8], zero pad
    input  logic [S_USER_W-1:0] s_tuser,   // cmd_valid[0], operation[2:1]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // scl_out, sda_out, busy_res, done_res,
                                           // nack, zero pad
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [7:0]          cfg_wdata
);

    state_t               state_reg;
    state_t               state_next;
    cfg_t                 cfg_reg;
    res_t                 res_next;
    logic                 m_valid_reg;
    logic [M_DATA_W-1:0]  m_data_reg;
    logic                 s_accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    i2cw_step u_step (
        .st         (state_reg),
        .cfg        (cfg_reg),
        .cmd_valid  (s_tuser[0]),
        .operation  (op_t'(s_tuser[2:1])),
        .write_data (s_tdata[7:0]),
        .sda_in     (s_tdata[8]),
        .nx         (state_next),
        .res        (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period <= HALF_PERIOD_RESET;
            cfg_reg.ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_HALF_PERIOD: cfg_reg.half_period <= cfg_wdata;
                REG_ACK_TIMEOUT: cfg_reg.ack_timeout <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase        <= PH_IDLE;
            state_reg.bit_index    <= 4'd0;
            state_reg.shift_byte   <= 8'd0;
            state_reg.delay_count  <= 8'd0;
            state_reg.poll_count   <= 8'd0;
            state_reg.scl          <= 1'b1;
            state_reg.sda          <= 1'b1;
            state_reg.nack_pending <= 1'b0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= {3'b000, res_next.nack, res_next.done, res_next.busy,
                           res_next.sda, res_next.scl};
        end
    end

    `I2CW_ASSERT_SAME(a_nack_needs_done, m_valid_reg && m_data_reg[4], m_data_reg[3])
    `I2CW_ASSERT_SAME(a_idle_no_delay, state_reg.phase == PH_IDLE, state_reg.delay_count == 8'd0)
    `I2CW_ASSERT_NEXT(a_idle_holds, s_accept && state_reg.phase == PH_IDLE && !s_tuser[0], state_reg.phase == PH_IDLE)
    `I2CW_ASSERT_NEXT(a_result_follows, s_accept, m_valid_reg)

endmodule

// ===== test/i2c_master_write_engine_core_test.sv =====
// ----------------------------------------------------------------------------
// I2C master write engine testbench
// Streams timebase tick requests into the write engine and checks every
// returned line-level result against a cycle-exact sequencer predictor
// or a typed row's expected levels. Starts with a directed tick table at
// reset settings, then runs random start/write/ack/stop transfers across
// several register settings and idle/stall mixes on both stream sides.
// ----------------------------------------------------------------------------
module i2c_master_write_engine_core_test;
    import i2cw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned SETTLE_TICKS = 8;
    localparam int          DIR_ROWS     = 17;
    localparam int          CHUNKS       = 8;

    // Positional fields: scl, sda, busy, done, nack.
    localparam res_t LINES_IDLE     = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
    localparam res_t LINES_RELEASED = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    localparam res_t LINES_LOW_BUSY = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

    typedef struct packed {
        logic        cv;
        op_t         op;
        logic [7:0]  wd;
        logic        sda;
        logic [15:0] reps;
        logic        typed;
        res_t        want;
    } tick_row_t;

    typedef struct packed {
        logic [7:0]  half_period;
        logic [7:0]  timeout;
        logic [15:0] commands;
    } setting_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [S_USER_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_we;
    logic                cfg_addr;
    logic [7:0]          cfg_wdata;

    // Predicted sequencer state and registers.
    phase_t     eng_phase;
    logic [3:0] eng_bit;
    logic [7:0] eng_shift;
    logic [7:0] eng_delay;
    logic [7:0] eng_polls;
    logic       eng_scl;
    logic       eng_sda;
    logic       eng_nack_hold;
    logic       eng_done;
    logic       eng_nack;
    logic [7:0] hp_reg;
    logic [7:0] to_reg;

    res_t        expected_levels[$];
    res_t        level_want;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned send_gap_by_mode[4]  = '{0, 87, 0, 21};
    int unsigned recv_stall_by_mode[4] = '{0, 0, 87, 21};

    tick_row_t directed_rows[DIR_ROWS] = '{
        '{1'b0, OP_START,    8'h00, 1'b0, 16'd2,   1'b1, LINES_IDLE},
        '{1'b1, OP_START,    8'h00, 1'b1, 16'd1,   1'b1, LINES_RELEASED},
        '{1'b1, OP_WRITE,    8'hFF, 1'b1, 16'd1,   1'b0, '0},
        '{1'b0, OP_START,    8'h00, 1'b0, 16'd13,  1'b0, '0},
        '{1'b1, OP_STOP,     8'h00, 1'b0, 16'd1,   1'b0, '0},
        '{1'b1, OP_WRITE,    8'hFF, 1'b0, 16'd1,   1'b1, LINES_LOW_BUSY},
        '{1'b0, OP_START,    8'h00, 1'b1, 16'd125, 1'b0, '0},
        '{1'b1, OP_ACK_WAIT, 8'h00, 1'b1, 16'd1,   1'b1, LINES_RELEASED},
        '{1'b0, OP_START,    8'h00, 1'b1, 16'd8,   1'b0, '0},
        '{1'b0, OP_START,    8'h00, 1'b0, 16'd6,   1'b0, '0},
        '{1'b1, OP_ACK_WAIT, 8'h00, 1'b0, 16'd1,   1'b0, '0},
        '{1'b0, OP_START,    8'h00, 1'b0, 16'd10,  1'b0, '0},
        '{1'b1, OP_STOP,     8'h00, 1'b1, 16'd1,   1'b1, LINES_LOW_BUSY},
        '{1'b0, OP_START,    8'h00, 1'b1, 16'd15,  1'b0, '0},
        '{1'b1, OP_START,    8'h00, 1'b0, 16'd1,   1'b0, '0},
        '{1'b1, OP_ACK_WAIT, 8'h3C, 1'b1, 16'd20,  1'b0, '0},
        '{1'b0, OP_ACK_WAIT, 8'hFF, 1'b0, 16'd6,   1'b0, '0}
    };

    setting_t settings[CHUNKS] = '{
        '{8'd1,   8'd1,   16'd6},
        '{8'd0,   8'd0,   16'd6},
        '{8'd2,   8'd6,   16'd4},
        '{8'd1,   8'd12,  16'd5},
        '{8'd3,   8'd2,   16'd3},
        '{8'd1,   8'd3,   16'd6},
        '{8'd2,   8'd1,   16'd4},
        '{8'd1,   8'd8,   16'd5}
    };

    i2c_master_write_engine_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] edge_spacing();
        return (hp_reg == 8'd0) ? 8'd1 : hp_reg;
    endfunction

    function automatic void end_sequence(logic with_nack);
        eng_phase     = PH_IDLE;
        eng_delay     = 8'd0;
        eng_nack_hold = 1'b0;
        eng_done      = 1'b1;
        eng_nack      = with_nack;
    endfunction

    function automatic void sample_ack(logic sda);
        if (!sda) begin
            eng_scl   = 1'b0;
            eng_delay = edge_spacing();
            eng_phase = PH_AK_FALL;
        end else if (eng_polls >= to_reg) begin
            eng_scl   = 1'b0;
            eng_delay = edge_spacing();
            eng_phase = PH_AK_DROP;
        end else begin
            eng_polls = eng_polls + 8'd1;
        end
    endfunction

    function automatic void next_edge(logic sda);
        case (eng_phase)
            PH_ST_A: begin
                eng_sda = 1'b0; eng_delay = edge_spacing(); eng_phase = PH_ST_B;
            end
            PH_ST_B: begin
                eng_scl = 1'b0; eng_delay = edge_spacing(); eng_phase = PH_ST_C;
            end
            PH_ST_C: end_sequence(1'b0);
            PH_SP_A: begin
                eng_scl = 1'b1; eng_delay = edge_spacing(); eng_phase = PH_SP_B;
            end
            PH_SP_B: begin
                eng_sda = 1'b1; eng_delay = edge_spacing(); eng_phase = PH_SP_C;
            end
            PH_SP_C: end_sequence(eng_nack_hold);
            PH_WR_LOW: begin
                eng_sda   = eng_shift[7];
                eng_delay = edge_spacing();
                eng_phase = PH_WR_DATA;
            end
            PH_WR_DATA: begin
                eng_scl = 1'b1; eng_delay = edge_spacing(); eng_phase = PH_WR_HIGH;
            end
            PH_WR_HIGH: begin
                eng_scl   = 1'b0;
                eng_shift = {eng_shift[6:0], 1'b0};
                eng_bit   = eng_bit + 4'd1;
                eng_delay = edge_spacing();
                eng_phase = (eng_bit >= 4'd8) ? PH_WR_END : PH_WR_LOW;
            end
            PH_WR_END: end_sequence(1'b0);
            PH_AK_RISE: begin
                eng_phase = PH_AK_POLL;
                sample_ack(sda);
            end
            PH_AK_FALL: end_sequence(1'b0);
            PH_AK_DROP: begin
                eng_sda       = 1'b0;
                eng_nack_hold = 1'b1;
                eng_delay     = edge_spacing();
                eng_phase     = PH_SP_A;
            end
            default: begin
                eng_phase = PH_IDLE;
                eng_delay = 8'd0;
            end
        endcase
    endfunction

    function automatic res_t sequencer_tick(logic cv, op_t op, logic [7:0] wd, logic sda);
        res_t lines;
        eng_done = 1'b0;
        eng_nack = 1'b0;
        if (eng_phase == PH_IDLE) begin
            if (cv) begin
                case (op)
                    OP_START: begin
                        eng_sda = 1'b1; eng_scl = 1'b1; eng_phase = PH_ST_A;
                    end
                    OP_STOP: begin
                        eng_sda = 1'b0; eng_nack_hold = 1'b0; eng_phase = PH_SP_A;
                    end
                    OP_WRITE: begin
                        eng_shift = wd; eng_bit = 4'd0; eng_scl = 1'b0;
                        eng_phase = PH_WR_LOW;
                    end
                    default: begin
                        eng_scl = 1'b1; eng_sda = 1'b1; eng_polls = 8'd0;
                        eng_phase = PH_AK_RISE;
                    end
                endcase
                eng_delay = edge_spacing();
            end
        end else if (eng_phase == PH_AK_POLL) begin
            sample_ack(sda);
        end else if (eng_delay > 8'd1) begin
            eng_delay = eng_delay - 8'd1;
        end else begin
            eng_delay = 8'd0;
            next_edge(sda);
        end
        lines.scl  = eng_scl;
        lines.sda  = eng_sda;
        lines.busy = (eng_phase != PH_IDLE);
        lines.done = eng_done;
        lines.nack = eng_nack;
        return lines;
    endfunction

    task automatic flag_error(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_line(string name, logic got, logic want);
        if (got !== want)
            flag_error($sformatf("%s got %b expected %b", name, got, want));
    endtask

    // One tick request; drive at negedge, hold until accepted, then predict.
    task automatic send_tick(logic cv, op_t op, logic [7:0] wd, logic sda,
                             logic typed, res_t typed_want);
        res_t predicted;
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-9){1'b0}}, sda, wd};
        s_tuser  <= {op, cv};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = sequencer_tick(cv, op, wd, sda);
        expected_levels.push_back(typed ? typed_want : predicted);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic addr, logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        if (addr == REG_HALF_PERIOD)
            hp_reg = value;
        else
            to_reg = value;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_levels.size() != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic run_transfers(int unsigned command_goal);
        op_t         plan_ops[$];
        logic [7:0]  plan_bytes[$];
        op_t         op;
        logic [7:0]  wd;
        logic        sda_bit;
        int unsigned issued;
        int unsigned ack_hold;
        int unsigned ack_seen;
        int unsigned extra;
        issued   = 0;
        ack_hold = 0;
        ack_seen = 0;
        while (issued < command_goal) begin
            if (eng_phase == PH_IDLE) begin
                if ($urandom_range(4) == 0) begin
                    send_tick(1'b0, op_t'($urandom_range(3)), pick_byte(),
                              1'($urandom_range(1)), 1'b0, '0);
                end else begin
                    if (plan_ops.size() == 0) begin
                        if ($urandom_range(99) < 85) begin
                            plan_ops.push_back(OP_START);    plan_bytes.push_back(pick_byte());
                            plan_ops.push_back(OP_WRITE);    plan_bytes.push_back(pick_byte());
                            plan_ops.push_back(OP_ACK_WAIT); plan_bytes.push_back(pick_byte());
                            extra = $urandom_range(3);
                            repeat (extra) begin
                                plan_ops.push_back(OP_WRITE);    plan_bytes.push_back(pick_byte());
                                plan_ops.push_back(OP_ACK_WAIT); plan_bytes.push_back(pick_byte());
                            end
                            plan_ops.push_back(OP_STOP);     plan_bytes.push_back(pick_byte());
                        end else begin
                            extra = $urandom_range(3, 1);
                            repeat (extra) begin
                                plan_ops.push_back(op_t'($urandom_range(3)));
                                plan_bytes.push_back(pick_byte());
                            end
                        end
                    end
                    op = plan_ops.pop_front();
                    wd = plan_bytes.pop_front();
                    send_tick(1'b1, op, wd, 1'($urandom_range(1)), 1'b0, '0);
                    issued++;
                    if (op == OP_ACK_WAIT) begin
                        ack_seen = 0;
                        if ($urandom_range(99) < 30)
                            ack_hold = edge_spacing() + to_reg + 2;
                        else
                            ack_hold = $urandom_range(32'(edge_spacing()) + 32'(to_reg));
                    end
                end
            end else begin
                sda_bit = 1'($urandom_range(1));
                if (eng_phase == PH_AK_RISE || eng_phase == PH_AK_POLL) begin
                    sda_bit = (ack_seen < ack_hold);
                    ack_seen++;
                end
                send_tick($urandom_range(3) == 0, op_t'($urandom_range(3)),
                          8'($urandom_range(255)), sda_bit, 1'b0, '0);
            end
        end
        while (eng_phase != PH_IDLE)
            send_tick(1'b0, OP_START, 8'h00, 1'b0, 1'b0, '0);
    endtask

    always @(negedge aclk)
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_levels.size() == 0) begin
                flag_error($sformatf("unexpected result %h", m_tdata));
            end else begin
                level_want = expected_levels.pop_front();
                check_line("scl_out", m_tdata[0], level_want.scl);
                check_line("sda_out", m_tdata[1], level_want.sda);
                check_line("busy",    m_tdata[2], level_want.busy);
                check_line("done",    m_tdata[3], level_want.done);
                check_line("nack",    m_tdata[4], level_want.nack);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** i2c_master_write_engine_core: FAILED **");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_HALF_PERIOD;
        cfg_wdata     = 8'd0;
        hp_reg        = HALF_PERIOD_RESET;
        to_reg        = ACK_TIMEOUT_RESET;
        eng_phase     = PH_IDLE;
        eng_bit       = 4'd0;
        eng_shift     = 8'd0;
        eng_delay     = 8'd0;
        eng_polls     = 8'd0;
        eng_scl       = 1'b1;
        eng_sda       = 1'b1;
        eng_nack_hold = 1'b0;
        eng_done      = 1'b0;
        eng_nack      = 1'b0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[r]) begin
            repeat (directed_rows[r].reps)
                send_tick(directed_rows[r].cv, directed_rows[r].op, directed_rows[r].wd,
                          directed_rows[r].sda, directed_rows[r].typed,
                          directed_rows[r].want);
        end

        foreach (settings[c]) begin
            settle();
            send_gap_pct   = send_gap_by_mode[c % 4];
            recv_stall_pct = recv_stall_by_mode[c % 4];
            write_reg(REG_HALF_PERIOD, settings[c].half_period);
            write_reg(REG_ACK_TIMEOUT, settings[c].timeout);
            cfg_we <= 1'b0;
            run_transfers(settings[c].commands);
        end

        s_tvalid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (error_count == 0)
            $display("** i2c_master_write_engine_core: PASSED **");
        else
            $display("** i2c_master_write_engine_core: FAILED **");
        $finish;
    end

endmodule
